### design/sdim_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sdim_pkg
// shared constants and types of the split data / instruction memory
// ----------------------------------------------------------------------------
package sdim_pkg;

  // default physical store sizes in bytes
  localparam int DATA_BYTES_DEF  = 65536;
  localparam int INSTR_BYTES_DEF = 65536;

  // field widths
  localparam int CMD_W   = 3;
  localparam int ADDR_W  = 16;
  localparam int WORD_W  = 32;
  localparam int LIMIT_W = 17;
  localparam int STAT_W  = 2;
  localparam int CFG_IW  = 2;

  // access commands
  localparam logic [CMD_W-1:0] CMD_RD_BYTE  = 3'd0;
  localparam logic [CMD_W-1:0] CMD_RD_WORD  = 3'd1;
  localparam logic [CMD_W-1:0] CMD_WR_BYTE  = 3'd2;
  localparam logic [CMD_W-1:0] CMD_WR_WORD  = 3'd3;
  localparam logic [CMD_W-1:0] CMD_RD_INSTR = 3'd4;
  localparam logic [CMD_W-1:0] CMD_WR_INSTR = 3'd5;

  // result status
  localparam logic [STAT_W-1:0] ST_OK     = 2'd0;
  localparam logic [STAT_W-1:0] ST_OOB    = 2'd1;
  localparam logic [STAT_W-1:0] ST_NOINIT = 2'd2;

  // configuration register indexes
  localparam logic [CFG_IW-1:0] REG_ENABLED     = 2'd0;
  localparam logic [CFG_IW-1:0] REG_DATA_BYTES  = 2'd1;
  localparam logic [CFG_IW-1:0] REG_INSTR_BYTES = 2'd2;

  // controller to datapath
  typedef struct packed {
    logic clear;
    logic load_in;
    logic exec;
    logic load_out;
  } sdim_ctl_t;

  // datapath to controller
  typedef struct packed {
    logic clear_last;
  } sdim_sts_t;

endpackage

### design/split_data_instruction_memory_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// split_data_instruction_memory_top
// byte-addressed data store and word-organized instruction store
// ----------------------------------------------------------------------------
// After reset the block sweeps both stores to zero, one row per cycle, over
// max((DATA_BYTES+1)/2, INSTR_BYTES/4) rows (32768 with the default sizes);
// in_stall stays high during the sweep while configuration writes are taken.
// After that, for each access, the word is captured, the single-port memories
// are read or written while the bounds are checked, and the registered read
// data is formatted into the output register once the result slot is free.
// The result register holds a finished word as the next access is accepted.
// The data store is split into an even-byte and an odd-byte bank so a 16-bit
// little-endian word at any address touches each bank once; the instruction
// store keeps one 32-bit big-endian word per row. Accesses are checked first
// against enabled, then against the size registers clipped to the physical
// store sizes; a failed access writes nothing and returns zero read data.
// ----------------------------------------------------------------------------
module split_data_instruction_memory_top #(
  parameter int DATA_BYTES  = sdim_pkg::DATA_BYTES_DEF,
  parameter int INSTR_BYTES = sdim_pkg::INSTR_BYTES_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  // configuration write channel
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [sdim_pkg::CFG_IW-1:0]    cfg_index,
  input  logic [sdim_pkg::LIMIT_W-1:0]   cfg_data,
  // access word in
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [sdim_pkg::CMD_W-1:0]     command,
  input  logic [sdim_pkg::ADDR_W-1:0]    address,
  input  logic [sdim_pkg::WORD_W-1:0]    write_data,
  // result word out
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [sdim_pkg::STAT_W-1:0]    status,
  output logic [sdim_pkg::WORD_W-1:0]    read_data,
  output logic                           misaligned
);

  sdim_pkg::sdim_ctl_t ctl;
  sdim_pkg::sdim_sts_t sts;

  // config writes always taken; user must write only while idle (not enforced)
  assign cfg_ready = 1'b1;

  sdim_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .ctl       (ctl)
  );

  sdim_dpath #(
    .DATA_BYTES  (DATA_BYTES),
    .INSTR_BYTES (INSTR_BYTES)
  ) u_dpath (
    .clk        (clk),
    .rst        (rst),
    .cfg_valid  (cfg_valid && cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .command    (command),
    .address    (address),
    .write_data (write_data),
    .ctl        (ctl),
    .sts        (sts),
    .status     (status),
    .read_data  (read_data),
    .misaligned (misaligned)
  );

endmodule

### design/sdim_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sdim_ram
// generic single-port ram with registered read
// ----------------------------------------------------------------------------
module sdim_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic                                       clk,
  input  logic                                       en,
  input  logic                                       we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] addr,
  input  logic [WIDTH-1:0]                           wdata,
  output logic [WIDTH-1:0]                           rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        mem[addr] <= wdata;
      end else begin
        rdata <= mem[addr];
      end
    end
  end

endmodule

### design/sdim_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sdim_ctrl
// sequencer: clearing sweep, then accept / access / result per word
// ----------------------------------------------------------------------------
module sdim_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  output logic                 out_valid,
  input  logic                 out_stall,
  input  sdim_pkg::sdim_sts_t  sts,
  output sdim_pkg::sdim_ctl_t  ctl
);

  localparam logic [1:0] S_CLEAR = 2'd0;
  localparam logic [1:0] S_IDLE  = 2'd1;
  localparam logic [1:0] S_EXEC  = 2'd2;
  localparam logic [1:0] S_DONE  = 2'd3;

  logic [1:0] state;
  logic [1:0] state_next;
  logic       slot_free;

  assign in_stall  = (state != S_IDLE);
  assign slot_free = !out_valid || !out_stall;

  always_comb begin
    ctl          = '0;
    state_next   = state;
    case (state)
      S_CLEAR: begin
        ctl.clear = 1'b1;
        if (sts.clear_last) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          ctl.load_in = 1'b1;
          state_next  = S_EXEC;
        end
      end
      S_EXEC: begin
        ctl.exec   = 1'b1;
        state_next = S_DONE;
      end
      S_DONE: begin
        if (slot_free) begin
          ctl.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (ctl.load_out) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

### design/sdim_dpath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sdim_dpath
// config registers, bounds checks, byte banks, instruction ram, result regs
// ----------------------------------------------------------------------------
module sdim_dpath #(
  parameter int DATA_BYTES  = sdim_pkg::DATA_BYTES_DEF,
  parameter int INSTR_BYTES = sdim_pkg::INSTR_BYTES_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_valid,
  input  logic [sdim_pkg::CFG_IW-1:0]    cfg_index,
  input  logic [sdim_pkg::LIMIT_W-1:0]   cfg_data,
  input  logic [sdim_pkg::CMD_W-1:0]     command,
  input  logic [sdim_pkg::ADDR_W-1:0]    address,
  input  logic [sdim_pkg::WORD_W-1:0]    write_data,
  input  sdim_pkg::sdim_ctl_t            ctl,
  output sdim_pkg::sdim_sts_t            sts,
  output logic [sdim_pkg::STAT_W-1:0]    status,
  output logic [sdim_pkg::WORD_W-1:0]    read_data,
  output logic                           misaligned
);

  // each data bank holds every other byte
  localparam int D_ROWS   = (DATA_BYTES + 1) / 2;
  localparam int DRW      = (D_ROWS > 1) ? $clog2(D_ROWS) : 1;
  localparam int I_ROWS   = INSTR_BYTES / 4;
  localparam int IRW      = (I_ROWS > 1) ? $clog2(I_ROWS) : 1;
  localparam int CLR_ROWS = (D_ROWS > I_ROWS) ? D_ROWS : I_ROWS;
  localparam int CW       = (CLR_ROWS > 1) ? $clog2(CLR_ROWS) : 1;
  localparam int LW       = sdim_pkg::LIMIT_W;
  localparam int AW       = sdim_pkg::ADDR_W;
  localparam logic [LW-1:0] D_MAX = LW'(DATA_BYTES);
  localparam logic [LW-1:0] I_MAX = LW'(INSTR_BYTES);

  // config registers
  logic          enabled;
  logic [LW-1:0] data_bytes_in_use;
  logic [LW-1:0] instr_bytes_in_use;

  always_ff @(posedge clk) begin
    if (rst) begin
      enabled            <= 1'b0;
      data_bytes_in_use  <= D_MAX | LW'(65536);
      instr_bytes_in_use <= I_MAX | LW'(65536);
    end else if (cfg_valid) begin
      case (cfg_index)
        sdim_pkg::REG_ENABLED:     enabled            <= cfg_data[0];
        sdim_pkg::REG_DATA_BYTES:  data_bytes_in_use  <= cfg_data;
        sdim_pkg::REG_INSTR_BYTES: instr_bytes_in_use <= cfg_data;
        default: ;
      endcase
    end
  end

  // clearing sweep
  logic [CW-1:0] clr_cnt;

  assign sts.clear_last = (clr_cnt == CW'(CLR_ROWS - 1));

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt <= '0;
    end else if (ctl.clear && !sts.clear_last) begin
      clr_cnt <= clr_cnt + 1'b1;
    end
  end

  // captured access
  logic [sdim_pkg::CMD_W-1:0]  cmd_q;
  logic [AW-1:0]               addr_q;
  logic [sdim_pkg::WORD_W-1:0] wdata_q;

  always_ff @(posedge clk) begin
    if (ctl.load_in) begin
      cmd_q   <= command;
      addr_q  <= address;
      wdata_q <= write_data;
    end
  end

  // checks
  logic [LW-1:0]               dlim;
  logic [LW-1:0]               ilim;
  logic [LW-1:0]               addr_ext;
  logic [LW-1:0]               instr_end;
  logic [sdim_pkg::STAT_W-1:0] st;
  logic                        ok;
  logic                        is_word;
  logic                        is_byte;
  logic                        is_instr;
  logic                        is_write;

  assign dlim      = (data_bytes_in_use > D_MAX) ? D_MAX : data_bytes_in_use;
  assign ilim      = (instr_bytes_in_use > I_MAX) ? I_MAX : instr_bytes_in_use;
  assign addr_ext  = LW'(addr_q);
  assign instr_end = {1'b0, addr_q[13:0], 2'b00} + LW'(3);

  assign is_byte  = (cmd_q == sdim_pkg::CMD_RD_BYTE) || (cmd_q == sdim_pkg::CMD_WR_BYTE);
  assign is_word  = (cmd_q == sdim_pkg::CMD_RD_WORD) || (cmd_q == sdim_pkg::CMD_WR_WORD);
  assign is_instr = (cmd_q == sdim_pkg::CMD_RD_INSTR) || (cmd_q == sdim_pkg::CMD_WR_INSTR);
  assign is_write = (cmd_q == sdim_pkg::CMD_WR_BYTE) || (cmd_q == sdim_pkg::CMD_WR_WORD) ||
                    (cmd_q == sdim_pkg::CMD_WR_INSTR);

  always_comb begin
    if (!enabled) begin
      st = sdim_pkg::ST_NOINIT;
    end else if (is_byte) begin
      st = (addr_ext < dlim) ? sdim_pkg::ST_OK : sdim_pkg::ST_OOB;
    end else if (is_word) begin
      st = ((addr_ext + LW'(1)) < dlim) ? sdim_pkg::ST_OK : sdim_pkg::ST_OOB;
    end else if (is_instr) begin
      st = (instr_end < ilim) ? sdim_pkg::ST_OK : sdim_pkg::ST_OOB;
    end else begin
      st = sdim_pkg::ST_OOB;
    end
  end

  assign ok = (st == sdim_pkg::ST_OK);

  // bank addressing: odd word start spills into the next even row
  logic [AW-1:0] row_lo;
  logic [AW-1:0] row_hi;
  logic          odd;
  logic          ev_en;
  logic          od_en;
  logic [7:0]    ev_wd;
  logic [7:0]    od_wd;

  assign odd    = addr_q[0];
  assign row_lo = addr_q >> 1;
  assign row_hi = row_lo + AW'(odd);
  assign ev_en  = ok && ((is_byte && !odd) || is_word);
  assign od_en  = ok && ((is_byte && odd) || is_word);
  assign ev_wd  = (is_word && odd) ? wdata_q[15:8] : wdata_q[7:0];
  assign od_wd  = (is_word && !odd) ? wdata_q[15:8] : wdata_q[7:0];

  logic           clr_d;
  logic           clr_i;
  logic           ev_ram_en;
  logic           od_ram_en;
  logic           in_ram_en;
  logic [DRW-1:0] ev_addr;
  logic [DRW-1:0] od_addr;
  logic [IRW-1:0] in_addr;
  logic [7:0]     ev_rd;
  logic [7:0]     od_rd;
  logic [31:0]    in_rd;

  assign clr_d     = ctl.clear && (32'(clr_cnt) < D_ROWS);
  assign clr_i     = ctl.clear && (32'(clr_cnt) < I_ROWS);
  assign ev_ram_en = clr_d || (ctl.exec && ev_en);
  assign od_ram_en = clr_d || (ctl.exec && od_en);
  assign in_ram_en = clr_i || (ctl.exec && ok && is_instr);
  assign ev_addr   = ctl.clear ? DRW'(clr_cnt) : DRW'(row_hi);
  assign od_addr   = ctl.clear ? DRW'(clr_cnt) : DRW'(row_lo);
  assign in_addr   = ctl.clear ? IRW'(clr_cnt) : IRW'(addr_q[13:0]);

  sdim_ram #(.WIDTH(8), .DEPTH(D_ROWS)) u_even (
    .clk   (clk),
    .en    (ev_ram_en),
    .we    (ctl.clear || is_write),
    .addr  (ev_addr),
    .wdata (ctl.clear ? 8'h00 : ev_wd),
    .rdata (ev_rd)
  );

  sdim_ram #(.WIDTH(8), .DEPTH(D_ROWS)) u_odd (
    .clk   (clk),
    .en    (od_ram_en),
    .we    (ctl.clear || is_write),
    .addr  (od_addr),
    .wdata (ctl.clear ? 8'h00 : od_wd),
    .rdata (od_rd)
  );

  // instruction words are stored big-endian, first byte in the top lane
  sdim_ram #(.WIDTH(32), .DEPTH(I_ROWS)) u_instr (
    .clk   (clk),
    .en    (in_ram_en),
    .we    (ctl.clear || is_write),
    .addr  (in_addr),
    .wdata (ctl.clear ? 32'h0 : wdata_q),
    .rdata (in_rd)
  );

  // result staging
  logic [sdim_pkg::STAT_W-1:0] st_q;
  logic                        mis_q;
  logic [7:0]                  lo_byte;
  logic [7:0]                  hi_byte;
  logic [31:0]                 rd_val;

  always_ff @(posedge clk) begin
    if (ctl.exec) begin
      st_q  <= st;
      mis_q <= ok && is_word && odd;
    end
  end

  assign lo_byte = odd ? od_rd : ev_rd;
  assign hi_byte = odd ? ev_rd : od_rd;

  always_comb begin
    rd_val = '0;
    if (st_q == sdim_pkg::ST_OK) begin
      case (cmd_q)
        sdim_pkg::CMD_RD_BYTE:  rd_val = {24'h0, lo_byte};
        sdim_pkg::CMD_RD_WORD:  rd_val = {16'h0, hi_byte, lo_byte};
        sdim_pkg::CMD_RD_INSTR: rd_val = in_rd;
        default:                rd_val = '0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load_out) begin
      status     <= st_q;
      read_data  <= rd_val;
      misaligned <= mis_q;
    end
  end

endmodule
